@@ rtl/core/quadratic_inequality_solver_defines.svh @@
// ----------------------------------------------------------------------------
// Quadratic inequality solver assertion macros
// Shared concurrent-check wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_INEQUALITY_SOLVER_DEFINES_SVH
`define QUADRATIC_INEQUALITY_SOLVER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QIS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qis: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define QIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qis: next-cycle check failed");

`endif

@@ rtl/core/qis_pkg.sv @@
// ----------------------------------------------------------------------------
// Quadratic inequality solver package
// Shared widths, status and relation codes, microcode format and program ROM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qis_pkg;

  // Datapath widths.
  localparam int unsigned RAD_W  = 34;  // discriminant magnitude bits
  localparam int unsigned ROOT_W = 33;  // square root bits
  localparam int unsigned REM_W  = 35;  // square root remainder bits
  localparam int unsigned NUM_W  = 35;  // dividend magnitude bits
  localparam int unsigned DEN_W  = 17;  // divisor magnitude bits
  localparam int unsigned PC_W   = 4;
  localparam int unsigned CNT_W  = 6;

  // Result status codes.
  localparam logic [2:0] ST_NOT_QUAD = 3'd0;
  localparam logic [2:0] ST_NO_ROOTS = 3'd1;
  localparam logic [2:0] ST_SINGLE   = 3'd2;
  localparam logic [2:0] ST_TWO      = 3'd3;
  localparam logic [2:0] ST_BETWEEN  = 3'd4;
  localparam logic [2:0] ST_OUTSIDE  = 3'd5;

  // Relation codes.
  localparam logic [1:0] OP_EQ = 2'd0;
  localparam logic [1:0] OP_GT = 2'd1;
  localparam logic [1:0] OP_LT = 2'd2;
  localparam logic [1:0] OP_XX = 2'd3;

  // Datapath operation selected by a control word.
  typedef enum logic [3:0] {
    U_IDLE,
    U_MUL_BB,
    U_MUL_AC,
    U_DISC,
    U_SQRT_INIT,
    U_SQRT_STEP,
    U_DIV_INIT,
    U_DIV_STEP,
    U_FINAL
  } uop_t;

  // Sequencing condition of a control word.
  typedef enum logic [2:0] {
    C_WAIT_IN,
    C_NEXT,
    C_EARLY,
    C_LOOP,
    C_WAIT_OUT
  } cond_t;

  typedef struct packed {
    uop_t              uop;
    cond_t             cond;
    logic [PC_W-1:0]   target;
    logic [CNT_W-1:0]  cnt;
  } ucode_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    uop_t uop;
    logic idle;
  } qis_ctrl_t;

  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);

  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_SQRT  = 4'd5;
  localparam logic [PC_W-1:0] PC_DIV   = 4'd7;
  localparam logic [PC_W-1:0] PC_FINAL = 4'd8;

  // Program ROM: one control word per step.
  function automatic ucode_t qis_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{uop: U_IDLE, cond: C_WAIT_IN, target: PC_IDLE, cnt: '0};
    case (pc)
      4'd0: w = '{uop: U_IDLE,      cond: C_WAIT_IN,  target: PC_IDLE,  cnt: '0};
      4'd1: w = '{uop: U_MUL_BB,    cond: C_NEXT,     target: PC_IDLE,  cnt: '0};
      4'd2: w = '{uop: U_MUL_AC,    cond: C_NEXT,     target: PC_IDLE,  cnt: '0};
      4'd3: w = '{uop: U_DISC,      cond: C_NEXT,     target: PC_IDLE,  cnt: '0};
      4'd4: w = '{uop: U_SQRT_INIT, cond: C_EARLY,    target: PC_FINAL, cnt: SQRT_LAST};
      4'd5: w = '{uop: U_SQRT_STEP, cond: C_LOOP,     target: PC_SQRT,  cnt: '0};
      4'd6: w = '{uop: U_DIV_INIT,  cond: C_NEXT,     target: PC_IDLE,  cnt: DIV_LAST};
      4'd7: w = '{uop: U_DIV_STEP,  cond: C_LOOP,     target: PC_DIV,   cnt: '0};
      4'd8: w = '{uop: U_FINAL,     cond: C_WAIT_OUT, target: PC_IDLE,  cnt: '0};
      default: w = '{uop: U_IDLE,   cond: C_WAIT_IN,  target: PC_IDLE,  cnt: '0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/quadratic_inequality_solver.sv @@
// ----------------------------------------------------------------------------
// Quadratic inequality solver
// Roots and relation class of a*x^2 + b*x + c from Q8.8 coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   An item enters on the in_ stream: in_tdata carries coef_a, coef_b and
//   coef_c (Q8.8), in_tuser carries the relation. One result leaves on the
//   out_ stream: out_tdata carries root_low and root_high (Q16.16, saturated),
//   out_tuser carries the status.
//   A microcoded sequencer runs one item at a time through one 16x16
//   multiplier, a bit-per-step square root unit and two bit-per-step dividers.
//   From acceptance to out_tvalid the sequencer runs setup steps (b*b, a*c,
//   discriminant, root load), a square root step per root bit, a divider
//   load, a divider step per dividend bit and a result step that loads the
//   output register; if a is zero or the discriminant negative, it skips the
//   root and divider steps. in_tready is high only while the sequencer waits
//   for an item, so none is taken until the last is in the output register.
//   The output register holds a result while out_tready is low; the next
//   item may be taken and worked on meanwhile, and the sequencer waits in its
//   result step until the register is free.
//   Reset clears the sequencer and the output valid; the block then waits
//   for an item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "quadratic_inequality_solver_defines.svh"

module quadratic_inequality_solver (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // coef_a [15:0], coef_b [31:16], coef_c [47:32]
  input  wire  [1:0]  in_tuser,   // operation [1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // root_low [31:0], root_high [63:32]
  output logic [2:0]  out_tuser   // status [2:0]
);

  qis_pkg::qis_ctrl_t ctrl;
  logic start, early, out_free;

  logic signed [15:0] a_r, b_r, c_r;
  logic [1:0]         op_r;
  logic signed [31:0] bb_r, ac_r;
  logic signed [34:0] d_r;
  logic               neg1_r, neg2_r;

  logic               out_valid_r;
  logic [2:0]         status_r;
  logic [31:0]        low_r, high_r;

  assign start    = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Early exit flags.
  logic a_zero, d_neg, d_zero;
  assign a_zero = (a_r == '0);
  assign d_neg  = d_r[34];
  assign d_zero = (d_r == '0);
  assign early  = a_zero || d_neg;

  qis_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .early    (early),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  assign in_tready = ctrl.idle;

  // Shared multiplier: b*b first, then a*c.
  logic signed [15:0] mul_x, mul_y;
  logic signed [31:0] prod;
  assign mul_x = (ctrl.uop == qis_pkg::U_MUL_BB) ? b_r : a_r;
  assign mul_y = (ctrl.uop == qis_pkg::U_MUL_BB) ? b_r : c_r;
  assign prod  = mul_x * mul_y;

  // Square root of the discriminant in Q.16.
  logic [qis_pkg::ROOT_W-1:0] root;
  qis_sqrt u_sqrt (
    .clk  (clk),
    .init (ctrl.uop == qis_pkg::U_SQRT_INIT),
    .step (ctrl.uop == qis_pkg::U_SQRT_STEP),
    .rad  (d_r[qis_pkg::RAD_W-1:0]),
    .root (root)
  );

  // Signed numerators -b*2^16 -/+ s and divisor 2a, split into magnitudes.
  logic signed [35:0] nb, num1, num2, sq;
  logic signed [16:0] den;
  logic [35:0]        num1_abs, num2_abs;
  logic [16:0]        den_abs;
  assign nb       = -($signed({{4{b_r[15]}}, b_r, 16'b0}));
  assign sq       = $signed({3'b000, root});
  assign num1     = nb - sq;
  assign num2     = nb + sq;
  assign num1_abs = num1[35] ? 36'(-num1) : 36'(num1);
  assign num2_abs = num2[35] ? 36'(-num2) : 36'(num2);
  assign den      = $signed({a_r, 1'b0});
  assign den_abs  = den[16] ? 17'(-den) : 17'(den);

  logic [qis_pkg::NUM_W-1:0] quo1, quo2;
  qis_div u_div1 (
    .clk  (clk),
    .init (ctrl.uop == qis_pkg::U_DIV_INIT),
    .step (ctrl.uop == qis_pkg::U_DIV_STEP),
    .num  (num1_abs[qis_pkg::NUM_W-1:0]),
    .den  (den_abs),
    .quo  (quo1)
  );
  qis_div u_div2 (
    .clk  (clk),
    .init (ctrl.uop == qis_pkg::U_DIV_INIT),
    .step (ctrl.uop == qis_pkg::U_DIV_STEP),
    .num  (num2_abs[qis_pkg::NUM_W-1:0]),
    .den  (den_abs),
    .quo  (quo2)
  );

  // Apply the quotient sign and saturate to Q16.16.
  logic [31:0] r1, r2;
  always_comb begin
    if (neg1_r) begin
      if (quo1[34:32] != '0 || (quo1[31] && quo1[30:0] != '0)) r1 = 32'h8000_0000;
      else r1 = 32'(-quo1[31:0]);
    end else begin
      if (quo1[34:31] != '0) r1 = 32'h7FFF_FFFF;
      else r1 = quo1[31:0];
    end
    if (neg2_r) begin
      if (quo2[34:32] != '0 || (quo2[31] && quo2[30:0] != '0)) r2 = 32'h8000_0000;
      else r2 = 32'(-quo2[31:0]);
    end else begin
      if (quo2[34:31] != '0) r2 = 32'h7FFF_FFFF;
      else r2 = quo2[31:0];
    end
  end

  // Classify the answer and order the roots.
  logic [1:0]  opn;
  logic [2:0]  status;
  logic [31:0] low, high;
  logic        a_pos;
  assign opn   = (op_r == qis_pkg::OP_XX) ? qis_pkg::OP_EQ : op_r;
  assign a_pos = !a_zero && !a_r[15];

  always_comb begin
    low    = '0;
    high   = '0;
    status = qis_pkg::ST_NOT_QUAD;
    if (a_zero) begin
      status = qis_pkg::ST_NOT_QUAD;
    end else if (d_neg) begin
      status = qis_pkg::ST_NO_ROOTS;
    end else begin
      low  = ($signed(r1) < $signed(r2)) ? r1 : r2;
      high = ($signed(r1) < $signed(r2)) ? r2 : r1;
      if (d_zero) begin
        case (opn)
          qis_pkg::OP_GT: status = a_pos ? qis_pkg::ST_OUTSIDE : qis_pkg::ST_SINGLE;
          qis_pkg::OP_LT: status = a_pos ? qis_pkg::ST_SINGLE : qis_pkg::ST_OUTSIDE;
          default:        status = qis_pkg::ST_SINGLE;
        endcase
      end else begin
        case (opn)
          qis_pkg::OP_GT: status = a_pos ? qis_pkg::ST_OUTSIDE : qis_pkg::ST_BETWEEN;
          qis_pkg::OP_LT: status = a_pos ? qis_pkg::ST_BETWEEN : qis_pkg::ST_OUTSIDE;
          default:        status = qis_pkg::ST_TWO;
        endcase
      end
    end
  end

  // Operand, product, discriminant and quotient sign registers.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= $signed(in_tdata[15:0]);
      b_r  <= $signed(in_tdata[31:16]);
      c_r  <= $signed(in_tdata[47:32]);
      op_r <= in_tuser;
    end
    if (ctrl.uop == qis_pkg::U_MUL_BB) bb_r <= prod;
    if (ctrl.uop == qis_pkg::U_MUL_AC) ac_r <= prod;
    if (ctrl.uop == qis_pkg::U_DISC) d_r <= 35'(bb_r) - (35'(ac_r) <<< 2);
    if (ctrl.uop == qis_pkg::U_DIV_INIT) begin
      neg1_r <= num1[35] ^ a_r[15];
      neg2_r <= num2[35] ^ a_r[15];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.uop == qis_pkg::U_FINAL && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.uop == qis_pkg::U_FINAL && out_free) begin
      status_r <= status;
      low_r    <= low;
      high_r   <= high;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {high_r, low_r};
  assign out_tuser  = status_r;

  // A result without real roots carries zero bounds.
  logic out_flat;
  assign out_flat = (out_tuser == qis_pkg::ST_NOT_QUAD) || (out_tuser == qis_pkg::ST_NO_ROOTS);

  // Checks.
  `QIS_ASSERT_NEXT(a_take_one, in_tvalid && in_tready, !in_tready)
  `QIS_ASSERT_SAME(a_flat_roots, out_tvalid && out_flat, out_tdata == '0)
  `QIS_ASSERT_SAME(a_ordered, out_tvalid, $signed(out_tdata[31:0]) <= $signed(out_tdata[63:32]))

endmodule

`default_nettype wire

@@ rtl/core/qis_useq.sv @@
// ----------------------------------------------------------------------------
// Quadratic inequality solver microsequencer
// Program counter, step counter and jump logic over the program ROM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qis_useq (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,     // item accepted this cycle
  input  wire               early,     // a is zero or discriminant negative
  input  wire               out_free,  // output register can take a result
  output qis_pkg::qis_ctrl_t ctrl
);

  logic [qis_pkg::PC_W-1:0]  pc_r, pc_nxt;
  logic [qis_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  qis_pkg::ucode_t           word;

  assign word      = qis_pkg::qis_rom(pc_r);
  assign ctrl.uop  = word.uop;
  assign ctrl.idle = (word.cond == qis_pkg::C_WAIT_IN);

  // Next step and loop count.
  always_comb begin
    pc_nxt  = pc_r;
    cnt_nxt = word.cnt;
    case (word.cond)
      qis_pkg::C_WAIT_IN: begin
        if (start) pc_nxt = pc_r + 1'b1;
      end
      qis_pkg::C_NEXT: begin
        pc_nxt = pc_r + 1'b1;
      end
      qis_pkg::C_EARLY: begin
        pc_nxt = early ? word.target : pc_r + 1'b1;
      end
      qis_pkg::C_LOOP: begin
        if (cnt_r == '0) begin
          pc_nxt = pc_r + 1'b1;
        end else begin
          pc_nxt  = word.target;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      qis_pkg::C_WAIT_OUT: begin
        if (out_free) pc_nxt = word.target;
      end
      default: begin
        pc_nxt = qis_pkg::PC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= qis_pkg::PC_IDLE;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/qis_sqrt.sv @@
// ----------------------------------------------------------------------------
// Quadratic inequality solver square root unit
// Restoring integer square root of d * 2^32, one result bit per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qis_sqrt (
  input  wire                        clk,
  input  wire                        init,
  input  wire                        step,
  input  wire  [qis_pkg::RAD_W-1:0]  rad,
  output logic [qis_pkg::ROOT_W-1:0] root
);

  logic [qis_pkg::RAD_W-1:0]  rad_r;
  logic [qis_pkg::REM_W-1:0]  rem_r;
  logic [qis_pkg::ROOT_W-1:0] root_r;
  logic [qis_pkg::REM_W+1:0]  rem_sh;
  logic [qis_pkg::REM_W+1:0]  trial;
  logic                       fits;

  // Bring down the next bit pair and compare against 4*root+1.
  assign rem_sh = {rem_r, rad_r[qis_pkg::RAD_W-1 -: 2]};
  assign trial  = (qis_pkg::REM_W+2)'({root_r, 2'b01});
  assign fits   = (rem_sh >= trial);
  assign root   = root_r;

  always_ff @(posedge clk) begin
    if (init) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (step) begin
      rad_r  <= {rad_r[qis_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= fits ? qis_pkg::REM_W'(rem_sh - trial) : qis_pkg::REM_W'(rem_sh);
      root_r <= {root_r[qis_pkg::ROOT_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/qis_div.sv @@
// ----------------------------------------------------------------------------
// Quadratic inequality solver divider
// Restoring unsigned division of magnitudes, one quotient bit per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qis_div (
  input  wire                       clk,
  input  wire                       init,
  input  wire                       step,
  input  wire  [qis_pkg::NUM_W-1:0] num,
  input  wire  [qis_pkg::DEN_W-1:0] den,
  output logic [qis_pkg::NUM_W-1:0] quo
);

  logic [qis_pkg::NUM_W-1:0] quo_r;  // dividend shifts out, quotient shifts in
  logic [qis_pkg::DEN_W-1:0] rem_r;
  logic [qis_pkg::DEN_W-1:0] den_r;
  logic [qis_pkg::DEN_W:0]   trial;
  logic                      fits;

  assign trial = {rem_r, quo_r[qis_pkg::NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (init) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (step) begin
      rem_r <= fits ? qis_pkg::DEN_W'(trial - {1'b0, den_r}) : qis_pkg::DEN_W'(trial);
      quo_r <= {quo_r[qis_pkg::NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ tb/quadratic_inequality_solver_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic inequality solver testbench
// Streams Q8.8 coefficient items with a relation code into the solver. Each
// accepted item is solved by a local root and status predictor. Each result
// is checked field by field against the oldest pending solution. The run
// covers a directed set of extremes and random items under three stall mixes.
// It also includes a long output hold-off and full drains between phases.
// ----------------------------------------------------------------------------

module quadratic_inequality_solver_tb;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AT_ITEM   = 550;
  localparam int HOLD_CYCLES    = 600;
  localparam int TAIL_CYCLES    = 100;

  // One coefficient item and one solution.
  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic [1:0]         op;
  } coef_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } root_sol_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // coef_a [15:0], coef_b [31:16], coef_c [47:32]
  logic [1:0]  in_tuser = '0;   // operation [1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // root_low [31:0], root_high [63:32]
  logic [2:0]  out_tuser;       // status [2:0]

  coef_item_t coef_q[$];
  root_sol_t  solution_q[$];
  coef_item_t offered_item;
  root_sol_t  want_sol;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_in = 0;
  int results_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;
  int directed_count = 0;
  int status_hits[6];

  quadratic_inequality_solver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Free-running clock.
  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // Floor of the square root of d * 2^32, one result bit per pass.
  function automatic longint sqrt_scaled(input longint d);
    logic [71:0] target;
    logic [35:0] root;
    logic [35:0] cand;
    int          i;
    target = {8'd0, d} << 32;
    root = '0;
    for (i = 34; i >= 0; i--) begin
      cand = root | (36'd1 << i);
      if (72'(cand) * 72'(cand) <= target) begin
        root = cand;
      end
    end
    return longint'(root);
  endfunction

  // Quotient truncated toward zero and clipped to the Q16.16 range.
  function automatic logic signed [31:0] div_clip(input longint num, input longint den);
    longint q;
    q = num / den;
    if (q > 64'sd2147483647) begin
      q = 64'sd2147483647;
    end else if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
    end
    return q[31:0];
  endfunction

  // Roots and relation class of one item.
  function automatic root_sol_t solve_quadratic(input coef_item_t it);
    longint     av, bv, cv, disc, s, nb, r1, r2;
    logic [1:0] rel;
    root_sol_t  r;
    av = it.a;
    bv = it.b;
    cv = it.c;
    rel = (it.op == qis_pkg::OP_XX) ? qis_pkg::OP_EQ : it.op;
    disc = bv * bv - 4 * av * cv;
    r.lo = '0;
    r.hi = '0;
    if (av == 0) begin
      r.status = qis_pkg::ST_NOT_QUAD;
    end else if (disc < 0) begin
      r.status = qis_pkg::ST_NO_ROOTS;
    end else begin
      s = sqrt_scaled(disc);
      nb = -bv * 65536;
      r1 = div_clip(nb - s, 2 * av);
      r2 = div_clip(nb + s, 2 * av);
      r.lo = (r1 < r2) ? r1[31:0] : r2[31:0];
      r.hi = (r1 < r2) ? r2[31:0] : r1[31:0];
      if (disc == 0) begin
        case (rel)
          qis_pkg::OP_EQ: r.status = qis_pkg::ST_SINGLE;
          qis_pkg::OP_GT: r.status = (av > 0) ? qis_pkg::ST_OUTSIDE : qis_pkg::ST_SINGLE;
          default:        r.status = (av > 0) ? qis_pkg::ST_SINGLE : qis_pkg::ST_OUTSIDE;
        endcase
      end else begin
        case (rel)
          qis_pkg::OP_EQ: r.status = qis_pkg::ST_TWO;
          qis_pkg::OP_GT: r.status = (av < 0) ? qis_pkg::ST_BETWEEN : qis_pkg::ST_OUTSIDE;
          default:        r.status = (av < 0) ? qis_pkg::ST_OUTSIDE : qis_pkg::ST_BETWEEN;
        endcase
      end
    end
    return r;
  endfunction

  function automatic coef_item_t make_coefs(input int av, input int bv, input int cv,
                                            input logic [1:0] op);
    coef_item_t it;
    it.a = 16'(av);
    it.b = 16'(bv);
    it.c = 16'(cv);
    it.op = op;
    return it;
  endfunction

  // Random item, biased toward real roots, double roots and large quotients.
  function automatic coef_item_t random_coefs();
    int pick, g, m, n, sgn, av, bv, cv;
    pick = $urandom_range(99);
    if (pick < 25) begin
      av = $signed(16'($urandom));
      bv = $signed(16'($urandom));
      cv = $signed(16'($urandom));
    end else if (pick < 45) begin
      // Perfect square g*(m*x +/- n)^2 gives a zero discriminant.
      do begin
        g = $urandom_range(1, 4);
        m = $urandom_range(1, 90);
        n = $urandom_range(0, 90);
      end while (g * m * m > 32767 || g * n * n > 32767 || 2 * g * m * n > 32767);
      sgn = $urandom_range(1) ? -1 : 1;
      av = sgn * g * m * m;
      cv = sgn * g * n * n;
      bv = ($urandom_range(1) ? -2 : 2) * g * m * n;
    end else if (pick < 75) begin
      // Opposite signs of a and c always leave two real roots.
      av = $signed(16'($urandom));
      if (av == 0) begin
        av = 1;
      end
      cv = (av > 0) ? -int'($urandom_range(32768, 1)) : int'($urandom_range(32767, 1));
      bv = $signed(16'($urandom));
    end else if (pick < 88) begin
      // Tiny a pushes the roots toward the saturation limits.
      av = int'($urandom_range(1, 8)) * ($urandom_range(1) ? -1 : 1);
      bv = $signed(16'($urandom));
      cv = int'($urandom_range(512)) - 256;
    end else if (pick < 96) begin
      av = int'($urandom_range(2047)) - 1024;
      bv = int'($urandom_range(2047)) - 1024;
      cv = int'($urandom_range(2047)) - 1024;
    end else begin
      av = 0;
      bv = $signed(16'($urandom));
      cv = $signed(16'($urandom));
    end
    return make_coefs(av, bv, cv, 2'($urandom_range(3)));
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at result %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // Driver: presents queued items, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        solution_q.push_back(solve_quadratic(offered_item));
        items_in <= items_in + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (coef_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered_item = coef_q.pop_front();
          in_tdata <= {offered_item.c, offered_item.b, offered_item.a};
          in_tuser <= offered_item.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off once the item count reaches a fixed point.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_in == HOLD_AT_ITEM) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver: random back-pressure, ready held low during the hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: checks each result against the oldest pending solution.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (solution_q.size() == 0) begin
        report_mismatch("result with nothing pending, status", out_tuser, -1);
      end else begin
        want_sol = solution_q.pop_front();
        if (out_tuser !== want_sol.status) begin
          report_mismatch("status", out_tuser, want_sol.status);
        end
        if (out_tdata[31:0] !== want_sol.lo) begin
          report_mismatch("root_low", $signed(out_tdata[31:0]), want_sol.lo);
        end
        if (out_tdata[63:32] !== want_sol.hi) begin
          report_mismatch("root_high", $signed(out_tdata[63:32]), want_sol.hi);
        end
      end
      if (out_tuser < 3'd6) begin
        status_hits[out_tuser]++;
      end
      results_seen++;
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus: directed extremes, then three random phases with full drains.
  initial begin
    int phase;
    int k;
    int phase_items[3];
    phase_items = '{230, 230, 240};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 29;
          rx_idle_pct = 69;
        end
        1: begin
          tx_idle_pct = 69;
          rx_idle_pct = 29;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        // Zero a, negative discriminant, extremes and saturation.
        coef_q.push_back(make_coefs(0, 0, 0, qis_pkg::OP_EQ));
        coef_q.push_back(make_coefs(0, -32768, 32767, qis_pkg::OP_GT));
        coef_q.push_back(make_coefs(-32768, -32768, -32768, qis_pkg::OP_LT));
        coef_q.push_back(make_coefs(32767, 32767, 32767, qis_pkg::OP_EQ));
        coef_q.push_back(make_coefs(-32768, -32768, 32767, qis_pkg::OP_EQ));
        coef_q.push_back(make_coefs(32767, 32767, -32768, qis_pkg::OP_GT));
        coef_q.push_back(make_coefs(1, -32768, 0, qis_pkg::OP_EQ));
        coef_q.push_back(make_coefs(-1, -32768, 0, qis_pkg::OP_LT));
        coef_q.push_back(make_coefs(1, 32767, -32768, qis_pkg::OP_XX));
        // Double root with each relation and both signs of a.
        coef_q.push_back(make_coefs(256, -512, 256, qis_pkg::OP_EQ));
        coef_q.push_back(make_coefs(256, -512, 256, qis_pkg::OP_GT));
        coef_q.push_back(make_coefs(256, -512, 256, qis_pkg::OP_LT));
        coef_q.push_back(make_coefs(-256, 512, -256, qis_pkg::OP_EQ));
        coef_q.push_back(make_coefs(-256, 512, -256, qis_pkg::OP_GT));
        coef_q.push_back(make_coefs(-256, 512, -256, qis_pkg::OP_LT));
        // Two roots with each relation for a > 0, GT and LT for a < 0, then double roots at zero.
        coef_q.push_back(make_coefs(256, 0, -256, qis_pkg::OP_EQ));
        coef_q.push_back(make_coefs(256, 0, -256, qis_pkg::OP_GT));
        coef_q.push_back(make_coefs(256, 0, -256, qis_pkg::OP_LT));
        coef_q.push_back(make_coefs(-256, 0, 256, qis_pkg::OP_GT));
        coef_q.push_back(make_coefs(-256, 0, 256, qis_pkg::OP_LT));
        coef_q.push_back(make_coefs(256, 0, 0, qis_pkg::OP_XX));
        coef_q.push_back(make_coefs(-32768, 0, 0, qis_pkg::OP_GT));
        directed_count = coef_q.size();
      end
      for (k = 0; k < phase_items[phase]; k++) begin
        coef_q.push_back(random_coefs());
      end
      // Pause the sender until every pending solution has been checked.
      while (coef_q.size() != 0 || in_tvalid || solution_q.size() != 0) begin
        @(negedge clk);
      end
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (solution_q.size() != 0) begin
      report_mismatch("solutions still pending at end", solution_q.size(), 0);
    end
    $display("Ran %0d items (%0d directed) under mixed stalls, drains and a long hold-off.",
             items_in, directed_count);
    $display("Statuses seen: not quad %0d, no roots %0d, single %0d, two %0d, %s %0d, %s %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             "between", status_hits[4], "outside", status_hits[5]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ quadratic_inequality_solver.f @@
+incdir+rtl/core
rtl/core/qis_pkg.sv
rtl/core/qis_useq.sv
rtl/core/qis_sqrt.sv
rtl/core/qis_div.sv
rtl/core/quadratic_inequality_solver.sv
tb/quadratic_inequality_solver_tb.sv
